/* sv/rexu_pkg.sv */
// ----------------------------------------------------------------------------
// rexu_pkg
// shared types and constants for the execute unit with condition flags
// ----------------------------------------------------------------------------
package rexu_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned OP_W   = 5;

  localparam logic [DATA_W-1:0] PTR_STEP = DATA_W'(4);

  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 5'd0,
    OP_SUB    = 5'd1,
    OP_MUL    = 5'd2,
    OP_AND    = 5'd3,
    OP_OR     = 5'd4,
    OP_XOR    = 5'd5,
    OP_ADDL   = 5'd6,
    OP_SUBL   = 5'd7,
    OP_MOVC   = 5'd8,
    OP_LOAD   = 5'd9,
    OP_LOADP  = 5'd10,
    OP_STORE  = 5'd11,
    OP_STOREP = 5'd12,
    OP_JALR   = 5'd13,
    OP_JUMP   = 5'd14,
    OP_BZ     = 5'd15,
    OP_BNZ    = 5'd16,
    OP_BP     = 5'd17,
    OP_BNP    = 5'd18,
    OP_BN     = 5'd19,
    OP_BNN    = 5'd20,
    OP_CMP    = 5'd21,
    OP_CML    = 5'd22,
    OP_NOP    = 5'd23,
    OP_HALT   = 5'd24
  } op_e;

  typedef struct packed {
    logic zero;
    logic positive;
    logic negative;
  } flags_t;

  typedef struct packed {
    logic   en;
    flags_t val;
  } flag_upd_t;

  typedef struct packed {
    logic [OP_W-1:0]          op;
    logic signed [DATA_W-1:0] first_value;
    logic signed [DATA_W-1:0] second_value;
    logic signed [DATA_W-1:0] immediate;
    logic signed [DATA_W-1:0] instr_address;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] result_value;
    logic signed [DATA_W-1:0] mem_address;
    logic signed [DATA_W-1:0] updated_pointer;
    logic                     redirect;
    logic signed [DATA_W-1:0] redirect_target;
    logic                     zero_out;
    logic                     positive_out;
    logic                     negative_out;
  } out_item_t;

endpackage

/* sv/rexu_in_if.sv */
// ----------------------------------------------------------------------------
// rexu_in_if
// instruction channel: valid/ready handshake carrying one decoded instruction
// ----------------------------------------------------------------------------
interface rexu_in_if import rexu_pkg::*; ();

  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          op;
  logic signed [DATA_W-1:0] first_value;
  logic signed [DATA_W-1:0] second_value;
  logic signed [DATA_W-1:0] immediate;
  logic signed [DATA_W-1:0] instr_address;

  modport source (
    output valid, op, first_value, second_value, immediate, instr_address,
    input  ready
  );

  modport sink (
    input  valid, op, first_value, second_value, immediate, instr_address,
    output ready
  );

endinterface

/* sv/rexu_out_if.sv */
// ----------------------------------------------------------------------------
// rexu_out_if
// result channel: valid/ready handshake carrying one execute result
// ----------------------------------------------------------------------------
interface rexu_out_if import rexu_pkg::*; ();

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] result_value;
  logic signed [DATA_W-1:0] mem_address;
  logic signed [DATA_W-1:0] updated_pointer;
  logic                     redirect;
  logic signed [DATA_W-1:0] redirect_target;
  logic                     zero_out;
  logic                     positive_out;
  logic                     negative_out;

  modport source (
    output valid, result_value, mem_address, updated_pointer, redirect,
           redirect_target, zero_out, positive_out, negative_out,
    input  ready
  );

  modport sink (
    input  valid, result_value, mem_address, updated_pointer, redirect,
           redirect_target, zero_out, positive_out, negative_out,
    output ready
  );

endinterface

/* sv/rexu_flags.sv */
// ----------------------------------------------------------------------------
// rexu_flags
// zero, positive and negative condition flag register
// ----------------------------------------------------------------------------
module rexu_flags import rexu_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  flag_upd_t upd_i,
  output flags_t    flags_o
);

  flags_t flags_q;
  flags_t flags_d;

  always_comb begin
    flags_d = flags_q;
    if (upd_i.en) begin
      flags_d = upd_i.val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else begin
      flags_q <= flags_d;
    end
  end

  assign flags_o = flags_q;

endmodule

/* sv/rexu_alu.sv */
// ----------------------------------------------------------------------------
// rexu_alu
// single-pass execute logic: alu, address generation, branch resolution
// ----------------------------------------------------------------------------
module rexu_alu import rexu_pkg::*; (
  input  in_item_t  item_i,
  input  flags_t    flags_i,
  output out_item_t res_o,
  output flag_upd_t upd_o
);

  logic [DATA_W-1:0] a;
  logic [DATA_W-1:0] b;
  logic [DATA_W-1:0] imm;
  logic [DATA_W-1:0] pc;
  logic [DATA_W-1:0] res;
  logic [DATA_W-1:0] addr;
  logic [DATA_W-1:0] ptr;
  logic [DATA_W-1:0] target;
  logic              redir;
  logic              take;
  logic              set_val;
  logic              set_cmp;
  logic              cmp_gt;
  logic              cmp_eq;
  logic              lit_gt;
  logic              lit_eq;
  flags_t            val_flags;
  flags_t            new_flags;
  op_e               op;

  assign a   = item_i.first_value;
  assign b   = item_i.second_value;
  assign imm = item_i.immediate;
  assign pc  = item_i.instr_address;
  assign op  = op_e'(item_i.op);

  assign cmp_gt = item_i.first_value > item_i.second_value;
  assign cmp_eq = a == b;
  assign lit_gt = item_i.first_value > item_i.immediate;
  assign lit_eq = a == imm;

  always_comb begin
    res     = '0;
    addr    = '0;
    ptr     = '0;
    target  = '0;
    redir   = 1'b0;
    take    = 1'b0;
    set_val = 1'b0;
    set_cmp = 1'b0;
    case (op)
      OP_ADD: begin
        res     = a + b;
        set_val = 1'b1;
      end
      OP_SUB: begin
        res     = a - b;
        set_val = 1'b1;
      end
      OP_MUL: begin
        res     = a * b;
        set_val = 1'b1;
      end
      OP_AND: begin
        res     = a & b;
        set_val = 1'b1;
      end
      OP_OR: begin
        res     = a | b;
        set_val = 1'b1;
      end
      OP_XOR: begin
        res     = a ^ b;
        set_val = 1'b1;
      end
      OP_ADDL: begin
        res     = a + imm;
        set_val = 1'b1;
      end
      OP_SUBL: begin
        res     = a - imm;
        set_val = 1'b1;
      end
      OP_MOVC:  res = imm;
      OP_LOAD:  addr = a + imm;
      OP_LOADP: begin
        addr = a + imm;
        ptr  = a + PTR_STEP;
      end
      OP_STORE: addr = b + imm;
      OP_STOREP: begin
        addr = b + imm;
        ptr  = b + PTR_STEP;
      end
      OP_JALR: begin
        res    = pc + PTR_STEP;
        redir  = 1'b1;
        target = a + imm;
      end
      OP_JUMP: begin
        redir  = 1'b1;
        target = a + imm;
      end
      OP_BZ:   take = flags_i.zero;
      OP_BNZ:  take = !flags_i.zero;
      OP_BP:   take = flags_i.positive;
      OP_BNP:  take = !flags_i.positive;
      OP_BN:   take = flags_i.negative;
      OP_BNN:  take = !flags_i.negative;
      OP_CMP:  set_cmp = 1'b1;
      OP_CML:  set_cmp = 1'b1;
      default: ;
    endcase
    if (take) begin
      redir  = 1'b1;
      target = pc + imm;
    end
  end

  // flags from an alu result read as signed
  always_comb begin
    val_flags.zero     = res == '0;
    val_flags.positive = (res != '0) && !res[DATA_W-1];
    val_flags.negative = res[DATA_W-1];
  end

  always_comb begin
    new_flags = flags_i;
    if (set_val) begin
      new_flags = val_flags;
    end else if (set_cmp) begin
      if (op == OP_CMP) begin
        new_flags.zero     = cmp_eq;
        new_flags.positive = cmp_gt;
        new_flags.negative = !cmp_gt && !cmp_eq;
      end else begin
        new_flags.zero     = lit_eq;
        new_flags.positive = lit_gt;
        new_flags.negative = !lit_gt && !lit_eq;
      end
    end
  end

  assign upd_o.en  = set_val || set_cmp;
  assign upd_o.val = new_flags;

  always_comb begin
    res_o.result_value    = res;
    res_o.mem_address     = addr;
    res_o.updated_pointer = ptr;
    res_o.redirect        = redir;
    res_o.redirect_target = target;
    res_o.zero_out        = new_flags.zero;
    res_o.positive_out    = new_flags.positive;
    res_o.negative_out    = new_flags.negative;
  end

endmodule

/* sv/risc_execute_unit_with_flags_top.sv */
// ----------------------------------------------------------------------------
// risc_execute_unit_with_flags_top
// execute stage of a small in-order risc core with condition flags
// ----------------------------------------------------------------------------
// Channels: in_i takes one decoded instruction per beat (op, two register
// values, immediate, instruction address); res_o gives one result beat per
// instruction, in order: alu value, memory address, updated pointer,
// redirect and target, and the flags after the instruction.
// Path: a beat accepted on in_i is held in the instruction register, executed
// in one pass of logic and held in the result register, which drives res_o.
// Throughput: one instruction per cycle unless res_o stalls, bounded by the
// multiplier and the adders between instruction and result registers. The
// flag register is written as the instruction moves into the result
// register, so the next instruction's branch sees the new flags at once.
// Reset: both stages empty, flags zero, in_i ready.
// Stall: when res_o is held off, the result register keeps its beat, the
// instruction register fills once more and then in_i.ready drops until the
// result is taken; no beat is lost or repeated.
// ----------------------------------------------------------------------------
module risc_execute_unit_with_flags_top import rexu_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  rexu_in_if.sink    in_i,
  rexu_out_if.source res_o
);

  in_item_t  s1_q;
  in_item_t  s1_d;
  logic      s1_valid_q;
  logic      s1_valid_d;
  out_item_t out_q;
  out_item_t out_d;
  logic      out_valid_q;
  logic      out_valid_d;
  logic      in_beat;
  logic      advance;
  flags_t    flags;
  flag_upd_t alu_upd;
  flag_upd_t flag_upd;

  assign advance   = s1_valid_q && (!out_valid_q || res_o.ready);
  assign in_i.ready = !s1_valid_q || advance;
  assign in_beat   = in_i.valid && in_i.ready;

  always_comb begin
    s1_d.op            = in_i.op;
    s1_d.first_value   = in_i.first_value;
    s1_d.second_value  = in_i.second_value;
    s1_d.immediate     = in_i.immediate;
    s1_d.instr_address = in_i.instr_address;
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_beat) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  rexu_alu u_alu (
    .item_i  (s1_q),
    .flags_i (flags),
    .res_o   (out_d),
    .upd_o   (alu_upd)
  );

  assign flag_upd.en  = alu_upd.en && advance;
  assign flag_upd.val = alu_upd.val;

  rexu_flags u_flags (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .upd_i   (flag_upd),
    .flags_o (flags)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      s1_q <= s1_d;
    end
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign res_o.valid           = out_valid_q;
  assign res_o.result_value    = out_q.result_value;
  assign res_o.mem_address     = out_q.mem_address;
  assign res_o.updated_pointer = out_q.updated_pointer;
  assign res_o.redirect        = out_q.redirect;
  assign res_o.redirect_target = out_q.redirect_target;
  assign res_o.zero_out        = out_q.zero_out;
  assign res_o.positive_out    = out_q.positive_out;
  assign res_o.negative_out    = out_q.negative_out;

  // at most one condition flag is ever set
  a_flags_onehot0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(flags))
    else $error("more than one condition flag set");

  // flags only move when an instruction leaves the execute register
  a_flags_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(flags))
    else $error("flags changed without an executed instruction");

  // a blocked instruction stays in the execute register unchanged
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !advance |=> s1_valid_q && $stable(s1_q))
    else $error("execute register lost a blocked instruction");

  // no target without a redirect
  a_target_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.redirect |-> out_q.redirect_target == '0)
    else $error("redirect target set without redirect");

endmodule
